// ===== rtl/rpl_pkg.sv =====
// ----------------------------------------------------------------------------
// rpl_pkg
// Shared constants, operation codes and controller/datapath types for the
// route prefix lookup unit.
// ----------------------------------------------------------------------------
package rpl_pkg;

  // Table geometry
  localparam int ENTRIES = 16;
  localparam int PORTS   = 4;

  // Field widths
  localparam int ADDR_W = 32;
  localparam int PORT_W = $clog2(PORTS);
  localparam int IDX_W  = 4;
  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // One stored route: masked prefix, mask, output port
  localparam int ROUTE_W = 2 * ADDR_W + PORT_W;

  // Operation codes carried in func
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_WRITE  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              wr_en;    // store the route on the input channel
    logic              start;    // latch lookup key, clear best match
    logic              rd_en;    // read one table slot
    logic [SLOT_W-1:0] rd_addr;  // slot being read
    logic              out_load; // move best match into the result register
  } rpl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free; // result register can take a new result this cycle
  } rpl_sts_t;

endpackage

// ===== rtl/rpl_if.sv =====
// ----------------------------------------------------------------------------
// rpl_in_if / rpl_out_if
// Valid/ready channels carrying lookup and write transactions in, and
// lookup results out.
// ----------------------------------------------------------------------------
interface rpl_in_if import rpl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [IDX_W-1:0]  entry_index;
  logic [ADDR_W-1:0] entry_prefix;
  logic [ADDR_W-1:0] entry_mask;
  logic [PORT_W-1:0] entry_port;
  logic              entry_valid;
  logic [ADDR_W-1:0] target_addr;
  logic [PORT_W-1:0] arrival_port;

  modport source (
    output valid, func, entry_index, entry_prefix, entry_mask, entry_port,
           entry_valid, target_addr, arrival_port,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_prefix, entry_mask, entry_port,
           entry_valid, target_addr, arrival_port,
    output ready
  );
endinterface

interface rpl_out_if import rpl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [PORT_W-1:0] out_port;
  logic [IDX_W-1:0]  route_index;

  modport source (output valid, hit, out_port, route_index, input ready);
  modport sink   (input valid, hit, out_port, route_index, output ready);
endinterface

// ===== rtl/route_prefix_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// route_prefix_lookup_unit
// Longest-prefix-match IPv4 route lookup over a small route table.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries two kinds of transaction, chosen by func. A write stores
//   one route (prefix, mask, port, active flag) at entry_index and gives no
//   result; an index beyond the table is dropped. A lookup gives
//   target_addr and arrival_port and yields one transaction on out_o with
//   hit, out_port and route_index (port and index 0 on a miss).
//   in_ready stays high after a write.
//   A lookup reads one table slot per cycle from the route RAM; the result
//   reaches the output register once the scan and the last compare are
//   done and the register is free, and in_ready rises in that same cycle;
//   in_ready is low from acceptance until then.
//   The table scan (one RAM read per slot) sets the lookup rate.
//   If out_o is stalled, the finished result stays in the output register
//   and the next transaction is still accepted; a second lookup result
//   waits in the controller until the register frees.
//   Reset clears all active flags, so the table is empty; prefix, mask and
//   port of a slot hold no defined value until written.
// ----------------------------------------------------------------------------
module route_prefix_lookup_unit import rpl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rpl_in_if.sink    in_i,
  rpl_out_if.source out_o
);

  rpl_cmd_t cmd;
  rpl_sts_t sts;

  rpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rpl_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .entry_index_i  (in_i.entry_index),
    .entry_prefix_i (in_i.entry_prefix),
    .entry_mask_i   (in_i.entry_mask),
    .entry_port_i   (in_i.entry_port),
    .entry_valid_i  (in_i.entry_valid),
    .target_addr_i  (in_i.target_addr),
    .arrival_port_i (in_i.arrival_port),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .hit_o          (out_o.hit),
    .out_port_o     (out_o.out_port),
    .route_index_o  (out_o.route_index)
  );

endmodule

// ===== rtl/rpl_ram.sv =====
// ----------------------------------------------------------------------------
// rpl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                              wr_data_i,
  input  logic                                          rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                              rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/rpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpl_ctrl
// Controller: accepts transactions, sequences the table scan of a lookup and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module rpl_ctrl import rpl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_func_i,
  output logic     in_ready_o,
  input  rpl_sts_t sts_i,
  output rpl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic              accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.rd_addr = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_func_i == FUNC_WRITE)) begin
          cmd_o.wr_en = 1'b1;
        end else if (accept) begin
          // slot 0 is read in the accepting cycle
          cmd_o.start = 1'b1;
          cmd_o.rd_en = 1'b1;
          if (ENTRIES == 1) begin
            state_d = ST_DRAIN;
          end else begin
            cnt_d   = SLOT_W'(1);
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (cnt_q == LAST_SLOT) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + SLOT_W'(1);
        end
      end
      ST_DRAIN: begin
        // last slot is compared this cycle
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/rpl_dpath.sv =====
// ----------------------------------------------------------------------------
// rpl_dpath
// Datapath: route table, per-slot match and distance compare, best-match
// tracking and the result register.
// ----------------------------------------------------------------------------
module rpl_dpath import rpl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpl_cmd_t          cmd_i,
  output rpl_sts_t          sts_o,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [ADDR_W-1:0] entry_prefix_i,
  input  logic [ADDR_W-1:0] entry_mask_i,
  input  logic [PORT_W-1:0] entry_port_i,
  input  logic              entry_valid_i,
  input  logic [ADDR_W-1:0] target_addr_i,
  input  logic [PORT_W-1:0] arrival_port_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hit_o,
  output logic [PORT_W-1:0] out_port_o,
  output logic [IDX_W-1:0]  route_index_o
);

  // Table write: slots beyond the table are dropped
  logic               wr_ok;
  logic [SLOT_W-1:0]  wr_slot;
  logic [ROUTE_W-1:0] wr_data;
  logic [ROUTE_W-1:0] rd_data;
  logic [ENTRIES-1:0] valid_q;

  assign wr_ok   = cmd_i.wr_en && (32'(entry_index_i) < ENTRIES);
  assign wr_slot = SLOT_W'(entry_index_i);
  // prefix is stored already masked
  assign wr_data = {entry_prefix_i & entry_mask_i, entry_mask_i, entry_port_i};

  rpl_ram #(
    .WIDTH (ROUTE_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_ok),
    .wr_addr_i (wr_slot),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (cmd_i.rd_addr),
    .rd_data_o (rd_data)
  );

  // Active flags live in flops so that reset clears them at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_ok) begin
      valid_q[wr_slot] <= entry_valid_i;
    end
  end

  // Slot under compare is the slot read in the previous cycle
  logic              eval_q;
  logic [SLOT_W-1:0] eval_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_q <= 1'b0;
    end else begin
      eval_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    eval_slot_q <= cmd_i.rd_addr;
  end

  // Lookup key
  logic [ADDR_W-1:0] addr_q;
  logic [PORT_W-1:0] arrive_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      addr_q   <= target_addr_i;
      arrive_q <= arrival_port_i;
    end
  end

  // Match and distance of the slot under compare
  logic [ADDR_W-1:0] rt_prefix;
  logic [ADDR_W-1:0] rt_mask;
  logic [PORT_W-1:0] rt_port;
  logic [ADDR_W-1:0] xor_dist;
  logic              match;
  logic              take;

  assign {rt_prefix, rt_mask, rt_port} = rd_data;
  assign xor_dist = rt_prefix ^ addr_q;
  assign match = valid_q[eval_slot_q] && (rt_port != arrive_q) &&
                 ((xor_dist & rt_mask) == '0);

  // Best match so far; found flag, not a sentinel distance
  logic              found_q;
  logic [ADDR_W-1:0] best_q;
  logic [SLOT_W-1:0] win_slot_q;
  logic [PORT_W-1:0] win_port_q;

  assign take = eval_q && match && (!found_q || (xor_dist < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.start) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q     <= xor_dist;
      win_slot_q <= eval_slot_q;
      win_port_q <= rt_port;
    end
  end

  // Result register
  logic              out_valid_q;
  logic              hit_q;
  logic [PORT_W-1:0] out_port_q;
  logic [IDX_W-1:0]  route_index_q;

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      hit_q         <= found_q;
      out_port_q    <= found_q ? win_port_q : '0;
      route_index_q <= found_q ? IDX_W'(win_slot_q) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign out_port_o    = out_port_q;
  assign route_index_o = route_index_q;

endmodule

// ===== rtl/rpl_checker.sv =====
// ----------------------------------------------------------------------------
// rpl_checker
// Port-level checks on the route prefix lookup unit, bound to the top level.
// ----------------------------------------------------------------------------
module rpl_checker import rpl_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_func_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              hit_i,
  input logic [PORT_W-1:0] out_port_i,
  input logic [IDX_W-1:0]  route_index_i
);

  logic lookup_acc;
  logic write_acc;

  assign lookup_acc = in_valid_i && in_ready_i && (in_func_i == FUNC_LOOKUP);
  assign write_acc  = in_valid_i && in_ready_i && (in_func_i == FUNC_WRITE);

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A write never blocks the next transaction
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_acc |=> in_ready_i)
    else $error("input blocked after a write");

  // A lookup holds the input for the whole table scan
  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_acc |=> !in_ready_i ##(ENTRIES) !in_ready_i)
    else $error("input reopened during a table scan");

  // A miss reports port and index zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !hit_i |-> (out_port_i == '0) && (route_index_i == '0))
    else $error("miss with nonzero port or index");

endmodule

bind route_prefix_lookup_unit rpl_checker u_rpl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_func_i     (in_i.func),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .hit_i         (out_o.hit),
  .out_port_i    (out_o.out_port),
  .route_index_i (out_o.route_index)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for route_prefix_lookup_unit. Route writes and
// lookups are sent on the input channel, and a local copy of the route table
// predicts the winning route of every lookup. Each result is checked field
// by field against the oldest prediction. Both channels idle at random, and
// there is a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import rpl_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int RST_CYCLES  = 11;
  localparam int SETTLE      = ENTRIES + 8;  // one lookup scan plus margin
  localparam int STALL_LIMIT = 4000;         // cycles with no transaction
  localparam int HOLD_CYCLES = 400;
  localparam int SHOWN_MAX   = 10;

  // One transaction on the input channel
  typedef struct packed {
    logic              func;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [PORT_W-1:0] port;
    logic              active;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] arrival;
  } route_req_t;

  // One lookup result
  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] port;
    logic [IDX_W-1:0]  index;
  } route_res_t;

  logic clk_i;
  logic rst_ni;

  rpl_in_if  in_if ();
  rpl_out_if out_if ();

  route_prefix_lookup_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Local copy of the route table
  logic [ADDR_W-1:0] shadow_prefix [ENTRIES];
  logic [ADDR_W-1:0] shadow_mask   [ENTRIES];
  logic [PORT_W-1:0] shadow_port   [ENTRIES];
  logic              shadow_valid  [ENTRIES];

  route_res_t pending_routes [$];

  int mismatches   = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;
  int quiet_cycles = 0;

  // Clock
  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // Longest-prefix winner over the local table
  function automatic route_res_t best_route(logic [ADDR_W-1:0] addr,
                                            logic [PORT_W-1:0] arrival);
    route_res_t        res;
    logic              found;
    logic [ADDR_W-1:0] best;
    logic [ADDR_W-1:0] xor_dist;
    res   = '0;
    found = 1'b0;
    best  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_port[i] != arrival) begin
        xor_dist = (shadow_prefix[i] & shadow_mask[i]) ^ addr;
        if ((xor_dist & shadow_mask[i]) == '0 && (!found || xor_dist < best)) begin
          found     = 1'b1;
          best      = xor_dist;
          res.hit   = 1'b1;
          res.port  = shadow_port[i];
          res.index = IDX_W'(i);
        end
      end
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] mask_of_len(int len);
    if (len == 0) return '0;
    return {ADDR_W{1'b1}} << (ADDR_W - len);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= SHOWN_MAX) $display("%0t %s", $realtime, msg);
  endtask

  // Receiver: random stalls, or a counted hold-off when requested
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      out_if.ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Predict on each accepted transaction, check each result, watchdog
  always @(posedge clk_i) begin
    route_req_t req;
    route_res_t got;
    route_res_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        req = '{in_if.func, in_if.entry_index, in_if.entry_prefix, in_if.entry_mask,
                in_if.entry_port, in_if.entry_valid, in_if.target_addr,
                in_if.arrival_port};
        if (req.func == FUNC_WRITE) begin
          if (int'(req.idx) < ENTRIES) begin
            shadow_prefix[req.idx] = req.prefix;
            shadow_mask[req.idx]   = req.mask;
            shadow_port[req.idx]   = req.port;
            shadow_valid[req.idx]  = req.active;
          end
        end else begin
          pending_routes.push_back(best_route(req.addr, req.arrival));
        end
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.hit, out_if.out_port, out_if.route_index};
        if (pending_routes.size() == 0) begin
          report_mismatch($sformatf("unexpected result hit %0d port %0d index %0d",
                                    got.hit, got.port, got.index));
        end else begin
          want = pending_routes.pop_front();
          if (got.hit !== want.hit || got.port !== want.port ||
              got.index !== want.index)
            report_mismatch($sformatf(
              "mismatch: exp hit %0d port %0d index %0d, got hit %0d port %0d index %0d",
              want.hit, want.port, want.index, got.hit, got.port, got.index));
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Send one transaction; valid stays high unless a gap follows
  task automatic send_txn(route_req_t req);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= req.func;
    in_if.entry_index  <= req.idx;
    in_if.entry_prefix <= req.prefix;
    in_if.entry_mask   <= req.mask;
    in_if.entry_port   <= req.port;
    in_if.entry_valid  <= req.active;
    in_if.target_addr  <= req.addr;
    in_if.arrival_port <= req.arrival;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_write(int idx, logic [ADDR_W-1:0] prefix,
                            logic [ADDR_W-1:0] mask, int port, logic active);
    route_req_t req;
    req        = '0;
    req.func   = FUNC_WRITE;
    req.idx    = IDX_W'(idx);
    req.prefix = prefix;
    req.mask   = mask;
    req.port   = PORT_W'(port);
    req.active = active;
    req.addr   = $urandom;
    req.arrival = PORT_W'($urandom_range(PORTS - 1));
    send_txn(req);
  endtask

  task automatic send_lookup(logic [ADDR_W-1:0] addr, int arrival);
    route_req_t req;
    req         = '0;
    req.func    = FUNC_LOOKUP;
    req.idx     = IDX_W'($urandom_range(ENTRIES - 1));
    req.prefix  = $urandom;
    req.mask    = $urandom;
    req.port    = PORT_W'($urandom_range(PORTS - 1));
    req.active  = 1'($urandom);
    req.addr    = addr;
    req.arrival = PORT_W'(arrival);
    send_txn(req);
  endtask

  // Drop valid, let every result arrive, then allow one scan to finish
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_routes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Lookups on a table with no active route
  task automatic test_empty_table();
    send_lookup(32'h0000_0000, 0);
    send_lookup(32'hFFFF_FFFF, 3);
  endtask

  // Nested prefixes, port exclusion, default route, ties and removal
  task automatic test_directed_routes();
    send_write(0, 32'h0A00_0000, mask_of_len(8), 1, 1'b1);
    send_write(1, 32'h0A01_0000, mask_of_len(16), 2, 1'b1);
    send_write(2, 32'h0A01_0200, mask_of_len(24), 3, 1'b1);
    send_lookup(32'h0A01_0203, 0);   // /24 wins
    send_lookup(32'h0A01_0909, 0);   // /16 wins
    send_lookup(32'h0A01_0203, 3);   // /24 sits on the arrival port
    send_lookup(32'h0B00_0000, 0);   // no route
    send_write(15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 1'b1);
    send_lookup(32'hFFFF_FFFF, 0);   // host route in the top slot
    // default route, prefix bits outside the mask
    send_write(5, 32'hDEAD_BEEF, 32'h0000_0000, 1, 1'b1);
    send_lookup(32'hFFFF_FFFF, 2);   // all-ones distance still hits
    send_write(6, 32'h1234_5678, 32'h0000_0000, 1, 1'b1);
    send_lookup(32'h0102_0304, 0);   // tie, lower slot wins
    send_write(5, 32'hDEAD_BEEF, 32'h0000_0000, 1, 1'b0);
    send_lookup(32'h0102_0304, 0);   // removed slot skipped
    send_write(3, 32'h0A01_02FF, 32'hFFFF_FF80, 0, 1'b1);
    send_lookup(32'h0A01_02C8, 1);
    send_lookup(32'h0000_0000, 3);
    send_write(6, 32'h0000_0000, 32'h0000_0000, 3, 1'b0);
    send_lookup(32'h0000_0000, 3);   // nothing left for this address
  endtask

  // Mostly well-formed routes, lookups aimed at stored prefixes
  task automatic test_random_traffic(int count);
    int                sel;
    int                slot;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] addr;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 25) begin
        mask = ($urandom_range(9) == 0) ? $urandom : mask_of_len($urandom_range(ADDR_W));
        send_write($urandom_range(ENTRIES - 1), $urandom, mask,
                   $urandom_range(PORTS - 1), $urandom_range(99) < 85);
      end else begin
        sel  = $urandom_range(99);
        slot = $urandom_range(ENTRIES - 1);
        if (sel < 65)
          addr = (shadow_prefix[slot] & shadow_mask[slot]) |
                 ($urandom & ~shadow_mask[slot]);
        else if (sel < 72)
          addr = '1;
        else if (sel < 78)
          addr = '0;
        else
          addr = $urandom;
        send_lookup(addr, $urandom_range(PORTS - 1));
      end
    end
  endtask

  // Receiver holds off while lookups keep coming, so the input stalls
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_left = HOLD_CYCLES;
    for (int n = 0; n < 8; n++)
      send_lookup((shadow_prefix[n] & shadow_mask[n]) | ($urandom & ~shadow_mask[n]),
                  $urandom_range(PORTS - 1));
    wait_drained();
  endtask

  // A burst, then a pause until every result is back, then more
  task automatic test_drain_pause();
    tx_idle_pct  = 19;
    rx_stall_pct = 19;
    test_random_traffic(20);
    wait_drained();
    test_random_traffic(20);
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_prefix[i] = '0;
      shadow_mask[i]   = '0;
      shadow_port[i]   = '0;
      shadow_valid[i]  = 1'b0;
    end
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.func          = FUNC_LOOKUP;
    in_if.entry_index   = '0;
    in_if.entry_prefix  = '0;
    in_if.entry_mask    = '0;
    in_if.entry_port    = '0;
    in_if.entry_valid   = 1'b0;
    in_if.target_addr   = '0;
    in_if.arrival_port  = '0;
    out_if.ready        = 1'b0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_directed_routes();
    wait_drained();

    // Idling phases: none, sender, receiver, both
    tx_idle_pct = 0;  rx_stall_pct = 0;  test_random_traffic(210);
    tx_idle_pct = 49; rx_stall_pct = 0;  test_random_traffic(210);
    tx_idle_pct = 0;  rx_stall_pct = 49; test_random_traffic(210);
    tx_idle_pct = 19; rx_stall_pct = 19; test_random_traffic(210);
    wait_drained();

    test_backpressure();
    test_drain_pause();
    wait_drained();

    if (pending_routes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_routes.size()));
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
